// ===== rtl/core/hms_pkg.sv =====
// shared types, constants and helpers for the streaming 64-bit mix hash
`default_nettype none
package hms_pkg;

    // multiplier and shift of the mix function
    localparam logic [63:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
    localparam int          MIX_SHIFT  = 47;
    localparam logic [31:0] SEED_RESET = 32'he17a1465;

    // what the back end does with the word of one beat
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_TAIL,
        KIND_FULL
    } t_hms_kind;

    // one classified beat as it sits in the queue
    typedef struct packed {
        logic [63:0] word;
        t_hms_kind   kind;
        logic        first;
        logic        last;
        logic [31:0] len;
    } t_hms_entry;

    // front to queue
    typedef struct packed {
        logic       valid;
        t_hms_entry entry;
    } t_hms_push;

    // back end to multiply unit
    typedef struct packed {
        logic        start;
        logic [63:0] operand;
    } t_hms_mul_req;

    // multiply unit to back end
    typedef struct packed {
        logic        done;
        logic [63:0] product;
    } t_hms_mul_rsp;

    // partial product steps of the 64-bit multiply
    typedef enum logic [1:0] {
        MS_LOW,
        MS_CROSS_LO,
        MS_CROSS_HI
    } t_hms_mul_step;

    // back end sequencer states
    typedef enum logic [3:0] {
        BK_IDLE,
        BK_START,
        BK_LEN,
        BK_ABSORB,
        BK_KEY1,
        BK_KEY2,
        BK_HASH,
        BK_END,
        BK_FIN,
        BK_OUT
    } t_hms_bk_state;

    // x xor (x >> 47)
    function automatic logic [63:0] fold(input logic [63:0] x);
        return x ^ (x >> MIX_SHIFT);
    endfunction

    // ones over the low count bytes
    function automatic logic [63:0] byte_mask(input logic [3:0] count);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            m[i*8 +: 8] = (4'(i) < count) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hms_if.sv =====
// stream channel interfaces for message beats and hash results
`default_nettype none
interface hms_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        first_item;
    logic        last_item;
    logic [31:0] message_length;

    modport source (
        output valid, data_word, byte_count, first_item, last_item, message_length,
        input  ready
    );
    modport sink (
        input  valid, data_word, byte_count, first_item, last_item, message_length,
        output ready
    );
endinterface

interface hms_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;

    modport source (
        output valid, hash_value,
        input  ready
    );
    modport sink (
        input  valid, hash_value,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/core/hms_front.sv =====
// front end: accepts message beats, masks the word and classifies the work
`default_nettype none
module hms_front (
    hms_in_if.sink            i_in,
    input  wire logic         i_full,
    output hms_pkg::t_hms_push o_push
);
    import hms_pkg::*;

    t_hms_kind kind;

    // accept whenever the queue has room
    assign i_in.ready = !i_full;

    // classify by byte count; above eight counts as a full word
    always_comb begin
        case (i_in.byte_count) inside
            4'd0:           kind = KIND_NONE;
            [4'd8:4'd15]:   kind = KIND_FULL;
            default:        kind = KIND_TAIL;
        endcase
    end

    // build the queue entry
    always_comb begin
        o_push.valid       = i_in.valid && !i_full;
        o_push.entry.word  = i_in.data_word & byte_mask(i_in.byte_count);
        o_push.entry.kind  = kind;
        o_push.entry.first = i_in.first_item;
        o_push.entry.last  = i_in.last_item;
        o_push.entry.len   = i_in.message_length;
    end

endmodule
`default_nettype wire

// ===== rtl/core/hms_queue.sv =====
// short queue of classified beats between front and back end
`default_nettype none
module hms_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire hms_pkg::t_hms_push  i_push,
    output logic                     o_full,
    input  wire logic                i_pop,
    output logic                     o_valid,
    output hms_pkg::t_hms_entry      o_head
);
    import hms_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_hms_entry    r_slot [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rd_ptr];

    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push.entry;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/hms_mul.sv =====
// 64-bit by mix-constant multiply, low half, one 32x32 product per cycle
`default_nettype none
module hms_mul (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire hms_pkg::t_hms_mul_req i_req,
    output hms_pkg::t_hms_mul_rsp      o_rsp
);
    import hms_pkg::*;

    t_hms_mul_step r_step;
    logic          r_busy;
    logic          r_done;
    logic [63:0]   r_a;
    logic [63:0]   r_acc;
    logic [31:0]   op_a, op_b;
    logic [63:0]   prod;

    // operand select: low x low, low x high, high x low
    always_comb begin
        op_a = (r_step == MS_CROSS_HI) ? r_a[63:32] : r_a[31:0];
        op_b = (r_step == MS_CROSS_LO) ? MIX_MUL[63:32] : MIX_MUL[31:0];
        prod = 64'(op_a) * 64'(op_b);
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= MS_LOW;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= MS_LOW;
            end else if (r_busy) begin
                case (r_step)
                    MS_LOW:      r_step <= MS_CROSS_LO;
                    MS_CROSS_LO: r_step <= MS_CROSS_HI;
                    MS_CROSS_HI: begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        r_step <= MS_LOW;
                    end
                    default:     r_step <= MS_LOW;
                endcase
            end
        end
    end

    // operand latch and accumulator
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.operand;
        end else if (r_busy) begin
            case (r_step)
                MS_LOW:  r_acc <= prod;
                default: r_acc[63:32] <= r_acc[63:32] + prod[31:0];
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/hms_back.sv =====
// back end: sequences the hash recurrence and holds the result beat
`default_nettype none
module hms_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [31:0]          i_seed,
    input  wire logic                 i_q_valid,
    input  wire hms_pkg::t_hms_entry  i_q_head,
    output logic                      o_q_pop,
    hms_out_if.source                 o_out
);
    import hms_pkg::*;

    t_hms_bk_state r_state, n_state;
    logic [63:0]   r_h, n_h;
    t_hms_entry    r_item;
    logic          r_out_valid;
    logic [63:0]   r_out_hash;
    logic          load_out;
    t_hms_mul_req  mul_req;
    t_hms_mul_rsp  mul_rsp;

    hms_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign o_out.valid      = r_out_valid;
    assign o_out.hash_value = r_out_hash;

    // state register and running hash
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_h     <= '0;
        end else begin
            r_state <= n_state;
            r_h     <= n_h;
        end
    end

    // next state, multiply requests and queue pop
    always_comb begin
        n_state         = r_state;
        n_h             = r_h;
        o_q_pop         = 1'b0;
        load_out        = 1'b0;
        mul_req.start   = 1'b0;
        mul_req.operand = r_h;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = BK_START;
                end
            end
            BK_START: begin
                if (r_item.first) begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = 64'(r_item.len);
                    n_state         = BK_LEN;
                end else begin
                    n_state = BK_ABSORB;
                end
            end
            BK_LEN: begin
                if (mul_rsp.done) begin
                    n_h     = 64'(i_seed) ^ mul_rsp.product;
                    n_state = BK_ABSORB;
                end
            end
            BK_ABSORB: begin
                case (r_item.kind)
                    KIND_FULL: begin
                        mul_req.start   = 1'b1;
                        mul_req.operand = r_item.word;
                        n_state         = BK_KEY1;
                    end
                    KIND_TAIL: begin
                        mul_req.start   = 1'b1;
                        mul_req.operand = r_h ^ r_item.word;
                        n_state         = BK_HASH;
                    end
                    default: n_state = BK_END;
                endcase
            end
            BK_KEY1: begin
                if (mul_rsp.done) begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = fold(mul_rsp.product);
                    n_state         = BK_KEY2;
                end
            end
            BK_KEY2: begin
                if (mul_rsp.done) begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = r_h ^ mul_rsp.product;
                    n_state         = BK_HASH;
                end
            end
            BK_HASH: begin
                if (mul_rsp.done) begin
                    n_h     = mul_rsp.product;
                    n_state = BK_END;
                end
            end
            BK_END: begin
                if (r_item.last) begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = fold(r_h);
                    n_state         = BK_FIN;
                end else begin
                    n_state = BK_IDLE;
                end
            end
            BK_FIN: begin
                if (mul_rsp.done) begin
                    n_state = BK_OUT;
                end
            end
            BK_OUT: begin
                // product holds until the next start
                if (!r_out_valid || o_out.ready) begin
                    load_out = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // current beat
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_head;
        end
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_hash <= fold(mul_rsp.product);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/hash64_mix_stream_unit.sv =====
// in the back end a full word takes two key multiplies and a hash multiply,
// a tail one; a first beat adds a length multiply, a last beat a final multiply
// throughput set by the one shared 32x32 multiplier: three products per 64-bit
// multiply, up to three multiplies per full word; the queue takes beats meanwhile
// synchronous active-low reset clears queue, sequencer and result valid,
// zeroes the running hash and loads the default seed
`default_nettype none
module hash64_mix_stream_unit #(
    parameter int P_QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    hms_in_if.sink           i_in,
    hms_out_if.source        o_out
);
    import hms_pkg::*;

    logic [31:0] r_seed;
    t_hms_push   push;
    t_hms_entry  q_head;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;

    // seed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_wdata;
        end
    end

    hms_front u_front (
        .i_in   (i_in),
        .i_full (q_full),
        .o_push (push)
    );

    hms_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    hms_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_seed    (r_seed),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule
`default_nettype wire

// ===== tb/tb_hash64_mix_stream_unit.sv =====
// self-checking testbench for the streaming 64-bit mix hash unit
module tb_hash64_mix_stream_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import hms_pkg::MIX_MUL;
    import hms_pkg::MIX_SHIFT;
    import hms_pkg::SEED_RESET;

    localparam int unsigned CYCLE_LIMIT  = 400_000;
    localparam int unsigned SETTLE       = 120;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned PHASE_BEATS  = 310;

    // one message beat as the sender queues it
    typedef struct {
        logic [63:0] word;
        logic [3:0]  count;
        logic        first;
        logic        last;
        logic [31:0] len;
    } t_beat;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    hms_in_if  beat_if ();
    hms_out_if hash_if ();

    hash64_mix_stream_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (beat_if),
        .o_out       (hash_if)
    );

    t_beat       beat_queue[$];
    logic [63:0] expected_hashes[$];
    logic [63:0] hash_state   = '0;
    logic [31:0] seed_shadow  = SEED_RESET;
    int unsigned src_gap      = 0;
    int unsigned sink_stall   = 0;
    bit          src_gap_en   = 1'b0;
    bit          sink_gap_en  = 1'b0;
    bit          pressure_go  = 1'b0;
    logic        sink_hold;
    int unsigned fail_count   = 0;
    int unsigned beats_queued = 0;
    int unsigned beats_taken  = 0;
    int unsigned msgs_queued  = 0;
    int unsigned hashes_seen  = 0;
    int unsigned cycle_count  = 0;

    // clock and known input levels from time zero
    initial begin
        clk                      = 1'b0;
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_wdata                = '0;
        beat_if.valid            = 1'b0;
        beat_if.data_word        = '0;
        beat_if.byte_count       = '0;
        beat_if.first_item       = 1'b0;
        beat_if.last_item        = 1'b0;
        beat_if.message_length   = '0;
        hash_if.ready            = 1'b0;
        forever #1 clk = ~clk;
    end

    // absorb one accepted beat into the hash and queue the finalized value on a last beat
    task automatic murmur_absorb(input logic [63:0] word, input logic [3:0] count,
                                 input logic first, input logic last,
                                 input logic [31:0] len);
        logic [63:0] h;
        logic [63:0] k;
        if (first)
            hash_state = {32'd0, seed_shadow} ^ ({32'd0, len} * MIX_MUL);
        h = hash_state;
        if (count >= 4'd8) begin
            k = word * MIX_MUL;
            k = k ^ (k >> MIX_SHIFT);
            k = k * MIX_MUL;
            h = (h ^ k) * MIX_MUL;
        end else if (count != 4'd0) begin
            h = (h ^ (word & ((64'd1 << (8 * count)) - 64'd1))) * MIX_MUL;
        end
        hash_state = h;
        if (last) begin
            h = h ^ (h >> MIX_SHIFT);
            h = h * MIX_MUL;
            h = h ^ (h >> MIX_SHIFT);
            expected_hashes.push_back(h);
        end
    endtask

    // beat driver: predict on accept, then offer the next beat after its gap
    always @(posedge clk) begin
        t_beat nb;
        if (!rst_n) begin
            beat_if.valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (beat_if.valid && beat_if.ready) begin
                murmur_absorb(beat_if.data_word, beat_if.byte_count, beat_if.first_item,
                              beat_if.last_item, beat_if.message_length);
                beats_taken++;
            end
            if (!beat_if.valid || beat_if.ready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    beat_if.valid <= 1'b0;
                end else if (beat_queue.size() != 0) begin
                    nb = beat_queue.pop_front();
                    beat_if.valid          <= 1'b1;
                    beat_if.data_word      <= nb.word;
                    beat_if.byte_count     <= nb.count;
                    beat_if.first_item     <= nb.first;
                    beat_if.last_item      <= nb.last;
                    beat_if.message_length <= nb.len;
                    src_gap = (src_gap_en && $urandom_range(0, 3) != 0) ?
                              $urandom_range(0, 10) : 0;
                end else begin
                    beat_if.valid <= 1'b0;
                end
            end
        end
    end

    // hash monitor: compare each result beat, then stall ready for a drawn count
    always @(posedge clk) begin
        logic [63:0] want;
        if (!rst_n) begin
            hash_if.ready <= 1'b0;
            sink_stall = 0;
        end else begin
            if (hash_if.valid && hash_if.ready) begin
                if (expected_hashes.size() == 0) begin
                    $error("hash_value: expected none, actual %h", hash_if.hash_value);
                    fail_count++;
                end else begin
                    want = expected_hashes.pop_front();
                    if (hash_if.hash_value !== want) begin
                        $error("hash_value: expected %h, actual %h", want, hash_if.hash_value);
                        fail_count++;
                    end
                    hashes_seen++;
                end
                sink_stall = sink_gap_en ? $urandom_range(0, 10) : 0;
            end
            if (sink_hold) begin
                hash_if.ready <= 1'b0;
            end else if (sink_stall != 0) begin
                sink_stall--;
                hash_if.ready <= 1'b0;
            end else begin
                hash_if.ready <= 1'b1;
            end
        end
    end

    // long result back-pressure, counted here once the stimulus asks for it
    initial begin
        sink_hold = 1'b0;
        wait (pressure_go);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic push_beat(input logic [63:0] word, input logic [3:0] count,
                             input logic first, input logic last, input logic [31:0] len);
        t_beat b;
        b.word  = word;
        b.count = count;
        b.first = first;
        b.last  = last;
        b.len   = len;
        beat_queue.push_back(b);
        beats_queued++;
    endtask

    // split a message into beats; the flags can be dropped to break the sequence
    task automatic push_message(input int unsigned nbytes, input bit drop_first,
                                input bit drop_last);
        int unsigned words;
        int unsigned rest;
        logic [31:0] len;
        bit          zero_close;
        words      = nbytes / 8;
        rest       = nbytes % 8;
        len        = ($urandom_range(0, 9) == 0) ? $urandom : nbytes;
        zero_close = (rest == 0) && (words != 0) && ($urandom_range(0, 1) == 1);
        if (nbytes == 0) begin
            push_beat(rand_word(), 4'd0, !drop_first, !drop_last, len);
        end else begin
            for (int i = 0; i < words; i++) begin
                push_beat(rand_word(), 4'd8, (i == 0) && !drop_first,
                          (i == words - 1) && (rest == 0) && !zero_close && !drop_last, len);
            end
            if (rest != 0)
                push_beat(rand_word(), 4'(rest), (words == 0) && !drop_first, !drop_last, len);
            else if (zero_close)
                push_beat(rand_word(), 4'd0, 1'b0, !drop_last, len);
        end
        msgs_queued++;
    endtask

    // mostly whole messages of random content, some noise and broken sequences
    task automatic random_phase(input int unsigned n_beats);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned nbytes;
        stop_at = beats_queued + n_beats;
        while (beats_queued < stop_at) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0)
                nbytes = $urandom_range(81, 256);
            else if ($urandom_range(0, 3) == 0)
                nbytes = $urandom_range(25, 80);
            else
                nbytes = $urandom_range(0, 24);
            if (pick < 84)
                push_message(nbytes, 1'b0, 1'b0);
            else if (pick < 90)
                push_beat(rand_word(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), $urandom);
            else if (pick < 95)
                push_message(nbytes, 1'b0, 1'b1);
            else
                push_message(nbytes, 1'b1, 1'($urandom_range(0, 1)));
        end
    endtask

    // wait for all beats taken and all hashes back, then let the back end go quiet
    task automatic wait_drained();
        while (beat_queue.size() != 0 || beat_if.valid || expected_hashes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        seed_shadow = value;
    endtask

    task automatic run_phase(input logic [31:0] seed, input bit src_gaps, input bit sink_gaps);
        write_seed(seed);
        src_gap_en  = src_gaps;
        sink_gap_en = sink_gaps;
        random_phase(PHASE_BEATS);
        wait_drained();
    endtask

    // stimulus sequence
    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: no first beat right after reset continues from a zero hash
        push_beat(64'hffff_ffff_ffff_ffff, 4'd8, 1'b0, 1'b1, 32'd0);
        // empty message
        push_beat(64'h0, 4'd0, 1'b1, 1'b1, 32'd0);
        // short tails at the byte extremes, high bytes must be ignored
        push_beat(64'hffff_ffff_ffff_ffff, 4'd1, 1'b1, 1'b1, 32'd1);
        push_beat(64'h0, 4'd7, 1'b1, 1'b1, 32'd7);
        push_beat(64'hffff_ffff_ffff_ffff, 4'd7, 1'b1, 1'b1, 32'd7);
        // exact word, ended on the data beat and by an empty closing beat
        push_beat(64'hffff_ffff_ffff_ffff, 4'd8, 1'b1, 1'b1, 32'd8);
        push_beat(64'h0123_4567_89ab_cdef, 4'd8, 1'b1, 1'b0, 32'd8);
        push_beat(64'hffff_ffff_ffff_ffff, 4'd0, 1'b0, 1'b1, 32'd8);
        // byte counts above eight act as a full word
        push_beat(64'hffff_ffff_ffff_ffff, 4'd15, 1'b1, 1'b1, 32'hffff_ffff);
        push_beat(64'h5555_5555_5555_5555, 4'd9, 1'b1, 1'b1, 32'd9);
        // declared length is trusted as given
        push_beat(64'haaaa_aaaa_aaaa_aaaa, 4'd3, 1'b1, 1'b1, 32'h8000_0000);
        // partial word inside a message is still absorbed as a tail
        push_beat(64'hffff_ffff_ffff_ffff, 4'd5, 1'b1, 1'b0, 32'd13);
        push_beat(64'hffff_ffff_ffff_ffff, 4'd8, 1'b0, 1'b1, 32'd13);
        // continue after a finished message without a first beat
        push_beat(64'h1234, 4'd2, 1'b0, 1'b1, 32'd0);
        // first beat with no bytes, then data
        push_beat(64'hffff_ffff_ffff_ffff, 4'd0, 1'b1, 1'b0, 32'd16);
        push_beat(64'hffff_ffff_ffff_ffff, 4'd8, 1'b0, 1'b0, 32'd16);
        push_beat(64'h0, 4'd8, 1'b0, 1'b1, 32'd16);
        // empty middle beat and empty last beat
        push_beat(64'hffff_ffff_ffff_ffff, 4'd8, 1'b1, 1'b0, 32'd8);
        push_beat(64'hffff_ffff_ffff_ffff, 4'd0, 1'b0, 1'b0, 32'd8);
        push_beat(64'h0, 4'd0, 1'b0, 1'b1, 32'd8);
        wait_drained();

        // random phases across seed settings
        run_phase(32'h0000_0000, 1'b0, 1'b0);

        // back-pressure: sender streams without gaps while results are held off
        write_seed(32'hffff_ffff);
        src_gap_en  = 1'b0;
        sink_gap_en = 1'b1;
        pressure_go = 1'b1;
        random_phase(PHASE_BEATS);
        wait_drained();

        run_phase($urandom, 1'b1, 1'b1);
        run_phase(SEED_RESET, 1'b1, 1'b0);
        run_phase($urandom, 1'b0, 1'b1);

        $display("run covered %0d beats in %0d message sequences, %0d hashes compared",
                 beats_taken, msgs_queued, hashes_seen);
        $display("seeds: reset default, zero, all ones, random; one long result hold-off");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
